FILE: hdl/cct_pkg.sv
// Shared types and constants for the calorimeter cluster trigger.
// Used by cct_decision and calorimeter_cluster_trigger; depends on nothing.
`default_nettype none

package cct_pkg;

    // Configuration port geometry.
    localparam int CfgIndexW = 4;
    localparam int CfgDataW  = 11;

    // Register indexes of the configuration port.
    typedef enum logic [CfgIndexW-1:0] {
        REG_EM_RATIO_FACTOR     = 4'd0,
        REG_HAD_RATIO_FACTOR    = 4'd1,
        REG_EM_LOW_THRESHOLD    = 4'd2,
        REG_EM_HIGH_THRESHOLD   = 4'd3,
        REG_HAD_LOW_THRESHOLD   = 4'd4,
        REG_HAD_HIGH_THRESHOLD  = 4'd5,
        REG_ECAL_JET_THRESHOLD  = 4'd6,
        REG_TOTAL_JET_THRESHOLD = 4'd7
    } cfg_index_t;

    // Reset values of the configuration registers.
    localparam logic [3:0]  RstEmRatioFactor    = 4'd1;
    localparam logic [3:0]  RstHadRatioFactor   = 4'd1;
    localparam logic [10:0] RstEmLowThreshold   = 11'd64;
    localparam logic [10:0] RstEmHighThreshold  = 11'd128;
    localparam logic [10:0] RstHadLowThreshold  = 11'd64;
    localparam logic [10:0] RstHadHighThreshold = 11'd128;
    localparam logic [10:0] RstEcalJetThreshold = 11'd256;
    localparam logic [10:0] RstTotalJetThresh   = 11'd512;

    // Window sums saturate at this value.
    localparam logic [7:0] WinSat = 8'hff;

    // Number of window rows; each row gives one bit per threshold.
    localparam int Rows = 3;

    // Configuration register set.
    typedef struct packed {
        logic [3:0]  em_ratio_factor;
        logic [3:0]  had_ratio_factor;
        logic [10:0] em_low_threshold;
        logic [10:0] em_high_threshold;
        logic [10:0] had_low_threshold;
        logic [10:0] had_high_threshold;
        logic [10:0] ecal_jet_threshold;
        logic [10:0] total_jet_threshold;
    } cfg_t;

    // One trigger decision.
    typedef struct packed {
        logic [5:0] em_bits;
        logic [5:0] photon_bits;
        logic [5:0] electron_bits;
        logic [5:0] hadron_bits;
        logic [1:0] jet_bits;
    } result_t;

endpackage

`default_nettype wire

FILE: hdl/cct_decision.sv
// Combinational trigger decision for one registered item: windows, ratios, thresholds.
// Depends on cct_pkg for the configuration and result types.
`default_nettype none

module cct_decision (
    input  wire cct_pkg::cfg_t    cfg,
    input  wire logic [63:0]      ecal_link_left,
    input  wire logic [63:0]      ecal_link_right,
    input  wire logic [63:0]      hcal_link,
    input  wire logic [2:0]       preshower_row,
    output cct_pkg::result_t      res
);

    logic [7:0]  cells [4][4];
    logic [9:0]  raw_win [3][3];
    logic [7:0]  win [3][3];
    logic [9:0]  hsum;
    logic [11:0] em_prod;
    logic [11:0] had_prod;
    logic [10:0] win_total;
    logic        em_ok;
    logic        had_ok;
    logic [2:0]  em1, em2, ph1, ph2, el1, el2, ha1, ha2;
    logic [9:0]  etot;
    logic [10:0] jet_total;

    always_comb
    begin
        // HCAL sum over the even bytes of the link.
        hsum = 10'(hcal_link[7:0]) + 10'(hcal_link[23:16])
             + 10'(hcal_link[39:32]) + 10'(hcal_link[55:48]);

        // Unpack the 4x4 grid: columns 0-1 from the left link, 2-3 from the right.
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (c < 2)
                begin
                    cells[r][c] = ecal_link_left[8*((c%2)+2*r) +: 8];
                end
                else
                begin
                    cells[r][c] = ecal_link_right[8*((c%2)+2*r) +: 8];
                end
            end
        end

        em1 = '0; em2 = '0; ph1 = '0; ph2 = '0;
        el1 = '0; el2 = '0; ha1 = '0; ha2 = '0;
        em_prod   = '0;
        had_prod  = '0;
        win_total = '0;
        em_ok     = 1'b0;
        had_ok    = 1'b0;

        // Each overlapping 2x2 window is tested on its own and ORed into its row.
        for (int r = 0; r < cct_pkg::Rows; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                raw_win[r][c] = 10'(cells[r][c]) + 10'(cells[r][c+1])
                              + 10'(cells[r+1][c]) + 10'(cells[r+1][c+1]);
                win[r][c] = (raw_win[r][c] > 10'(cct_pkg::WinSat))
                          ? cct_pkg::WinSat : raw_win[r][c][7:0];
                win_total = 11'(win[r][c]) + 11'(hsum);
                em_prod   = 12'(win[r][c]) * 12'(cfg.em_ratio_factor);
                had_prod  = 12'(win[r][c]) * 12'(cfg.had_ratio_factor);
                em_ok     = 12'(hsum) < em_prod;
                had_ok    = 12'(hsum) > had_prod;

                if (em_ok && (win_total > cfg.em_low_threshold))
                begin
                    em1[r] = 1'b1;
                    el1[r] = el1[r] | preshower_row[r];
                    ph1[r] = ph1[r] | ~preshower_row[r];
                end
                if (em_ok && (win_total > cfg.em_high_threshold))
                begin
                    em2[r] = 1'b1;
                    el2[r] = el2[r] | preshower_row[r];
                    ph2[r] = ph2[r] | ~preshower_row[r];
                end
                if (had_ok && (win_total > cfg.had_low_threshold))
                begin
                    ha1[r] = 1'b1;
                end
                if (had_ok && (win_total > cfg.had_high_threshold))
                begin
                    ha2[r] = 1'b1;
                end
            end
        end

        // Jet sums over the four corner windows.
        etot = 10'(win[0][0]) + 10'(win[0][2]) + 10'(win[2][0]) + 10'(win[2][2]);
        jet_total = 11'(etot) + 11'(hsum);

        res.em_bits       = {em2, em1};
        res.photon_bits   = {ph2, ph1};
        res.electron_bits = {el2, el1};
        res.hadron_bits   = {ha2, ha1};
        res.jet_bits[0]   = 11'(etot) > cfg.ecal_jet_threshold;
        res.jet_bits[1]   = jet_total > cfg.total_jet_threshold;
    end

endmodule

`default_nettype wire

FILE: hdl/calorimeter_cluster_trigger.sv
// Top level of the calorimeter cluster trigger: handshake pipeline and config registers.
// Depends on cct_pkg and cct_decision.
//
// Usage:
//   Input channel (in_valid/in_ready) carries two ECAL links, one HCAL link and
//   the preshower byte. Each accepted transaction produces exactly one result
//   transaction on the output channel (out_valid/out_ready).
//   An accepted item is held in the input register and then moves into the
//   result register, which drives out_valid and the result outputs.
//   Throughput: one transaction per cycle while out_ready does not stall the
//   output; the decision logic is a single combinational pass between the
//   input register and the result register.
//   Stalls: when out_ready is low the result register holds its transaction,
//   the input register fills, and in_ready drops only when both are full.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always
//   ready; an index beyond the register list is ignored. Writes are expected
//   only while no transaction is in flight.
//   Reset: rst_n clears the valid flags of both pipeline stages and restores all
//   configuration registers to their default values.
`default_nettype none

module calorimeter_cluster_trigger (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] ecal_link_left,
    input  wire logic [63:0] ecal_link_right,
    input  wire logic [63:0] hcal_link,
    input  wire logic [7:0]  preshower_bits,
    // Output channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [5:0]       em_bits,
    output logic [5:0]       photon_bits,
    output logic [5:0]       electron_bits,
    output logic [5:0]       hadron_bits,
    output logic [1:0]       jet_bits,
    // Configuration channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [cct_pkg::CfgIndexW-1:0] cfg_index,
    input  wire logic [cct_pkg::CfgDataW-1:0]  cfg_data
);

    cct_pkg::cfg_t    cfg_reg;
    cct_pkg::result_t res_next;
    cct_pkg::result_t res_reg;

    logic        in_valid_reg;
    logic        out_valid_reg;
    logic [63:0] left_reg;
    logic [63:0] right_reg;
    logic [63:0] hcal_reg;
    logic [2:0]  pres_reg;
    logic        stage_advance;
    logic        in_take;

    // The result register frees when empty or being taken; the input register
    // moves forward whenever the result register can take it.
    assign stage_advance = !out_valid_reg || out_ready;
    assign in_ready      = !in_valid_reg || stage_advance;
    assign in_take       = in_valid && in_ready;
    assign cfg_ready     = 1'b1;

    // Pipeline valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (stage_advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers of both stages.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            left_reg  <= ecal_link_left;
            right_reg <= ecal_link_right;
            hcal_reg  <= hcal_link;
            pres_reg  <= preshower_bits[2:0];
        end
        if (stage_advance && in_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.em_ratio_factor     <= cct_pkg::RstEmRatioFactor;
            cfg_reg.had_ratio_factor    <= cct_pkg::RstHadRatioFactor;
            cfg_reg.em_low_threshold    <= cct_pkg::RstEmLowThreshold;
            cfg_reg.em_high_threshold   <= cct_pkg::RstEmHighThreshold;
            cfg_reg.had_low_threshold   <= cct_pkg::RstHadLowThreshold;
            cfg_reg.had_high_threshold  <= cct_pkg::RstHadHighThreshold;
            cfg_reg.ecal_jet_threshold  <= cct_pkg::RstEcalJetThreshold;
            cfg_reg.total_jet_threshold <= cct_pkg::RstTotalJetThresh;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cct_pkg::REG_EM_RATIO_FACTOR:
                    cfg_reg.em_ratio_factor     <= cfg_data[3:0];
                cct_pkg::REG_HAD_RATIO_FACTOR:
                    cfg_reg.had_ratio_factor    <= cfg_data[3:0];
                cct_pkg::REG_EM_LOW_THRESHOLD:
                    cfg_reg.em_low_threshold    <= cfg_data;
                cct_pkg::REG_EM_HIGH_THRESHOLD:
                    cfg_reg.em_high_threshold   <= cfg_data;
                cct_pkg::REG_HAD_LOW_THRESHOLD:
                    cfg_reg.had_low_threshold   <= cfg_data;
                cct_pkg::REG_HAD_HIGH_THRESHOLD:
                    cfg_reg.had_high_threshold  <= cfg_data;
                cct_pkg::REG_ECAL_JET_THRESHOLD:
                    cfg_reg.ecal_jet_threshold  <= cfg_data;
                cct_pkg::REG_TOTAL_JET_THRESHOLD:
                    cfg_reg.total_jet_threshold <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Decision logic between the input register and the result register.
    cct_decision u_decision (
        .cfg             (cfg_reg),
        .ecal_link_left  (left_reg),
        .ecal_link_right (right_reg),
        .hcal_link       (hcal_reg),
        .preshower_row   (pres_reg),
        .res             (res_next)
    );

    assign out_valid     = out_valid_reg;
    assign em_bits       = res_reg.em_bits;
    assign photon_bits   = res_reg.photon_bits;
    assign electron_bits = res_reg.electron_bits;
    assign hadron_bits   = res_reg.hadron_bits;
    assign jet_bits      = res_reg.jet_bits;

endmodule

`default_nettype wire
